// File: sv/tga_rle_pixel_decoder_assert.svh
// Assertion macros for the TGA RLE pixel decoder checker.
// No dependencies; included by the checker file.
`ifndef TGA_RLE_PIXEL_DECODER_ASSERT_SVH
`define TGA_RLE_PIXEL_DECODER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define TGARLE_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tga rle decoder check failed");

// Next-cycle implication, disabled during reset.
`define TGARLE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tga rle decoder check failed");

`endif

// File: sv/tgarle_pkg.sv
// Shared types and constants for the TGA RLE pixel decoder.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tgarle_pkg;

    localparam logic [1:0] CFG_BPP   = 2'd0;
    localparam logic [1:0] CFG_RLE   = 2'd1;
    localparam logic [1:0] CFG_TOTAL = 2'd2;

    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_PULL = 1'b1;

    localparam logic [2:0] BPP_RESET = 3'd3;
    localparam logic [2:0] BPP_BGRA  = 3'd4;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic       run_more;
        logic       image_last;
    } t_result;

endpackage

`default_nettype wire

// File: sv/tga_rle_pixel_decoder.sv
// TGA RLE pixel decoder: top level joining input register, decode core and result register.
// Depends on tgarle_pkg, tgarle_in_reg, tgarle_core, tgarle_out_reg.
//
// Usage:
//   Slave stream carries one request per beat: tuser = operation (0 push a
//   compressed byte, 1 pull the next pending run copy), tdata = data_byte.
//   Master stream carries decoded pixels: tdata = R,G,B,A from bit 0 up,
//   tuser = run_more, tlast = last pixel of the image.
//   Config port writes bytes_per_pixel (0), rle_mode (1), pixel_total (2);
//   write only while no request is in flight.
//   A pixel reaches the master side through the input register, then the
//   result register, after the request that completes it is accepted.
//   Throughput: one request per cycle unless the sink stalls; the decode
//   state is updated by a single pass of logic as the request leaves the
//   input register. Requests that produce no pixel pass through the same way.
//   Reset (synchronous, active low) clears the decode state and loads the
//   config defaults: 3 bytes per pixel, RLE on, one pixel.
//   When the sink stalls the result register holds, the input register
//   fills and o_s_tready drops until the sink takes the pixel.
`timescale 1ns / 1ps
`default_nettype none

module tga_rle_pixel_decoder
    import tgarle_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [7:0]  i_s_tdata,   // [7:0] data_byte
    input  wire logic        i_s_tuser,   // [0] operation
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [31:0]      o_m_tdata,   // [7:0] red, [15:8] green, [23:16] blue, [31:24] alpha
    output logic             o_m_tuser,   // [0] run_more
    output logic             o_m_tlast,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data
);

    logic       in_valid;
    logic       in_op;
    logic [7:0] in_byte;
    logic       out_free;
    logic       advance;
    logic       load;
    logic       res_valid;
    t_result    res;
    t_result    out_res;

    assign advance    = in_valid && out_free;
    assign o_s_tready = !in_valid || out_free;
    assign load       = i_s_tvalid && o_s_tready;

    tgarle_in_reg u_in (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_load    (load),
        .i_advance (advance),
        .i_op      (i_s_tuser),
        .i_byte    (i_s_tdata),
        .o_valid   (in_valid),
        .o_op      (in_op),
        .o_byte    (in_byte)
    );

    tgarle_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_step      (advance),
        .i_op        (in_op),
        .i_byte      (in_byte),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    tgarle_out_reg u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (res_valid),
        .i_res   (res),
        .i_ready (i_m_tready),
        .o_free  (out_free),
        .o_valid (o_m_tvalid),
        .o_res   (out_res)
    );

    assign o_m_tdata = {out_res.alpha, out_res.blue, out_res.green, out_res.red};
    assign o_m_tuser = out_res.run_more;
    assign o_m_tlast = out_res.image_last;

endmodule

`default_nettype wire

// File: sv/tgarle_in_reg.sv
// Input register for the TGA RLE pixel decoder: holds one request until it advances.
// Depends on nothing but the clock and reset.
`timescale 1ns / 1ps
`default_nettype none

module tgarle_in_reg (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_load,
    input  wire logic       i_advance,
    input  wire logic       i_op,
    input  wire logic [7:0] i_byte,
    output logic            o_valid,
    output logic            o_op,
    output logic [7:0]      o_byte
);

    logic       r_valid;
    logic       r_op;
    logic [7:0] r_byte;
    logic       n_valid;

    always_comb begin
        n_valid = r_valid;
        if (i_advance) begin
            n_valid = 1'b0;
        end
        if (i_load) begin
            n_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_op   <= i_op;
            r_byte <= i_byte;
        end
    end

    assign o_valid = r_valid;
    assign o_op    = r_op;
    assign o_byte  = r_byte;

endmodule

`default_nettype wire

// File: sv/tgarle_core.sv
// Decode state, configuration registers and per-request step logic.
// Depends on tgarle_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tgarle_core
    import tgarle_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data,
    input  wire logic        i_step,
    input  wire logic        i_op,
    input  wire logic [7:0]  i_byte,
    output logic             o_res_valid,
    output t_result          o_res
);

    logic [2:0]  r_bpp;
    logic        r_rle;
    logic [31:0] r_total;

    logic        r_expect_hdr;
    logic        r_is_run;
    logic [7:0]  r_left;
    logic [1:0]  r_slot;
    logic [31:0] r_hold;
    logic [31:0] r_done;

    logic        n_expect_hdr;
    logic        n_is_run;
    logic [7:0]  n_left;
    logic [1:0]  n_slot;
    logic [31:0] n_hold;
    logic [31:0] n_done;

    logic        wide;
    logic        pending;
    logic        finished;
    logic        last;
    logic        emit;
    logic        more;
    logic [31:0] done_inc;
    logic        slot_full;

    assign wide      = (r_bpp == BPP_BGRA);
    assign pending   = r_expect_hdr && r_is_run && (r_left != 8'd0);
    assign finished  = (r_done >= r_total);
    assign done_inc  = r_done + 32'd1;
    assign last      = (done_inc == r_total);
    assign slot_full = wide ? (r_slot == 2'd3) : (r_slot >= 2'd2);

    always_comb begin
        n_expect_hdr = r_expect_hdr;
        n_is_run     = r_is_run;
        n_left       = r_left;
        n_slot       = r_slot;
        n_hold       = r_hold;
        n_done       = r_done;
        emit         = 1'b0;
        more         = 1'b0;
        if (i_step && !finished) begin
            if (i_op == OP_PULL) begin
                if (pending) begin
                    n_left = r_left - 8'd1;
                    emit   = 1'b1;
                    more   = (n_left != 8'd0);
                end
            end else if (!pending) begin
                if (r_rle && r_expect_hdr) begin
                    n_is_run     = i_byte[7];
                    n_left       = i_byte[7] ? {1'b0, i_byte[6:0]}
                                             : ({1'b0, i_byte[6:0]} + 8'd1);
                    n_expect_hdr = 1'b0;
                    n_slot       = 2'd0;
                end else begin
                    case (r_slot)
                        2'd0:    n_hold = {24'd0, i_byte};
                        2'd1:    n_hold = {r_hold[31:16], i_byte, r_hold[7:0]};
                        2'd2:    n_hold = {r_hold[31:24], i_byte, r_hold[15:0]};
                        default: n_hold = {i_byte, r_hold[23:0]};
                    endcase
                    if (!slot_full) begin
                        n_slot = r_slot + 2'd1;
                    end else begin
                        n_slot = 2'd0;
                        emit   = 1'b1;
                        if (!r_rle) begin
                            more = 1'b0;
                        end else if (r_is_run) begin
                            n_expect_hdr = 1'b1;
                            more         = (r_left != 8'd0);
                        end else begin
                            n_left = r_left - 8'd1;
                            if (n_left == 8'd0) begin
                                n_expect_hdr = 1'b1;
                            end
                        end
                    end
                end
            end
            if (emit) begin
                n_done = done_inc;
                if (last) begin
                    n_left = 8'd0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bpp        <= BPP_RESET;
            r_rle        <= 1'b1;
            r_total      <= 32'd1;
            r_expect_hdr <= 1'b1;
            r_is_run     <= 1'b0;
            r_left       <= 8'd0;
            r_slot       <= 2'd0;
            r_hold       <= 32'd0;
            r_done       <= 32'd0;
        end else begin
            r_expect_hdr <= n_expect_hdr;
            r_is_run     <= n_is_run;
            r_left       <= n_left;
            r_slot       <= n_slot;
            r_hold       <= n_hold;
            r_done       <= n_done;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_BPP:   r_bpp   <= i_cfg_data[2:0];
                    CFG_RLE:   r_rle   <= i_cfg_data[0];
                    CFG_TOTAL: r_total <= i_cfg_data;
                    default:   ;
                endcase
            end
        end
    end

    assign o_res_valid     = emit;
    assign o_res.red       = n_hold[23:16];
    assign o_res.green     = n_hold[15:8];
    assign o_res.blue      = n_hold[7:0];
    assign o_res.alpha     = wide ? n_hold[31:24] : 8'd0;
    assign o_res.run_more  = more && !last;
    assign o_res.image_last = last;

endmodule

`default_nettype wire

// File: sv/tgarle_out_reg.sv
// Result register for the TGA RLE pixel decoder: holds a pixel until the sink takes it.
// Depends on tgarle_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tgarle_out_reg
    import tgarle_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_load,
    input  wire t_result i_res,
    input  wire logic    i_ready,
    output logic         o_free,
    output logic         o_valid,
    output t_result      o_res
);

    logic    r_valid;
    t_result r_res;
    logic    n_valid;

    assign o_free = !r_valid || i_ready;

    always_comb begin
        n_valid = r_valid;
        if (i_ready) begin
            n_valid = 1'b0;
        end
        if (i_load) begin
            n_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

`default_nettype wire

// File: sv/tgarle_checker.sv
// Port-level checks for the TGA RLE pixel decoder, bound to the top level.
// Depends on tga_rle_pixel_decoder_assert.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "tga_rle_pixel_decoder_assert.svh"

module tgarle_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        o_s_tready,
    input  wire logic        o_m_tvalid,
    input  wire logic        i_m_tready,
    input  wire logic [31:0] o_m_tdata,
    input  wire logic        o_m_tuser,
    input  wire logic        o_m_tlast,
    input  wire logic        i_cfg_we
);

    logic r_img_done;
    logic n_img_done;

    always_comb begin
        n_img_done = r_img_done;
        if (o_m_tvalid && i_m_tready && o_m_tlast) begin
            n_img_done = 1'b1;
        end
        if (i_cfg_we) begin
            n_img_done = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_img_done <= 1'b0;
        end else begin
            r_img_done <= n_img_done;
        end
    end

    // stalled pixel holds
    `TGARLE_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_m_tvalid && !i_m_tready, o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tlast))

    // the image's last pixel never claims pending copies
    `TGARLE_ASSERT_NOW(a_last_no_more, i_clk, i_rst_n, o_m_tvalid, !(o_m_tlast && o_m_tuser))

    // empty result register means the input side is open
    `TGARLE_ASSERT_NOW(a_ready_when_empty, i_clk, i_rst_n, !o_m_tvalid, o_s_tready)

    // no pixel after the image is complete until reconfigured
    `TGARLE_ASSERT_NOW(a_quiet_after_end, i_clk, i_rst_n, r_img_done, !o_m_tvalid)

endmodule

bind tga_rle_pixel_decoder tgarle_checker u_tgarle_checker (.*);

`default_nettype wire
